// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

  localparam int MAX_RESULTS       = 7;
  localparam int JOB_DEPTH_DEFAULT = 4;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       quote_single;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
  } res_entry_t;

  // All results caused by one input byte, entry 0 first.
  typedef struct packed {
    logic [2:0]                        count;
    res_entry_t [MAX_RESULTS-1:0]      res;
  } job_t;

  typedef struct packed {
    logic valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/jsu_front.sv -----
module jsu_front
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t in_data,
  output logic     job_push,
  output job_t     job
);

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ESCAPE  = 2'd1,
    MODE_UNICODE = 2'd2
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;

  mode_t       mode, mode_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [11:0] code_value, code_value_next;
  logic [7:0]  held_digits [3];
  logic        held_wr;

  always_comb begin
    logic [7:0]  c;
    logic [7:0]  quote;
    logic [2:0]  n;
    logic        closed;
    logic        do_normal;
    hex_t        h;
    logic [15:0] v;

    c         = in_data.in_byte;
    quote     = in_data.quote_single ? CH_SQUOTE : CH_DQUOTE;
    n         = 3'd0;
    closed    = 1'b0;
    do_normal = 1'b0;
    h         = hex_decode(c);
    v         = {code_value, h.value};
    held_wr   = 1'b0;
    job       = '0;
    mode_next        = mode;
    digit_count_next = digit_count;
    code_value_next  = code_value;

    case (mode)
      MODE_NORMAL: begin
        do_normal = 1'b1;
      end
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        case (c)
          CH_B:      begin job.res[n] = '{8'h08, KIND_DATA}; n = n + 3'd1; end
          CH_N:      begin job.res[n] = '{8'h0A, KIND_DATA}; n = n + 3'd1; end
          CH_R:      begin job.res[n] = '{8'h0D, KIND_DATA}; n = n + 3'd1; end
          CH_T:      begin job.res[n] = '{8'h09, KIND_DATA}; n = n + 3'd1; end
          CH_F:      begin job.res[n] = '{8'h0C, KIND_DATA}; n = n + 3'd1; end
          CH_BSLASH, CH_SLASH, CH_DQUOTE: begin
            job.res[n] = '{c, KIND_DATA}; n = n + 3'd1;
          end
          CH_U: begin
            mode_next        = MODE_UNICODE;
            digit_count_next = 2'd0;
            code_value_next  = 12'd0;
          end
          default: begin
            job.res[n] = '{CH_BSLASH, KIND_DATA}; n = n + 3'd1;
            job.res[n] = '{c, KIND_DATA};         n = n + 3'd1;
          end
        endcase
      end
      MODE_UNICODE: begin
        if (h.valid) begin
          if (digit_count != 2'd3) begin
            held_wr          = 1'b1;
            code_value_next  = {code_value[7:0], h.value};
            digit_count_next = digit_count + 2'd1;
          end else begin
            if (v < 16'h0080) begin
              job.res[n] = '{{1'b0, v[6:0]}, KIND_DATA}; n = n + 3'd1;
            end else if (v < 16'h0800) begin
              job.res[n] = '{{2'b11, v[11:6]}, KIND_DATA}; n = n + 3'd1;
              job.res[n] = '{{2'b10, v[5:0]}, KIND_DATA};  n = n + 3'd1;
            end else begin
              job.res[n] = '{{4'hE, v[15:12]}, KIND_DATA}; n = n + 3'd1;
              job.res[n] = '{{2'b10, v[11:6]}, KIND_DATA}; n = n + 3'd1;
              job.res[n] = '{{2'b10, v[5:0]}, KIND_DATA};  n = n + 3'd1;
            end
            mode_next        = MODE_NORMAL;
            digit_count_next = 2'd0;
            code_value_next  = 12'd0;
          end
        end else begin
          job.res[n] = '{CH_BSLASH, KIND_DATA}; n = n + 3'd1;
          job.res[n] = '{CH_U, KIND_DATA};      n = n + 3'd1;
          mode_next        = MODE_NORMAL;
          digit_count_next = 2'd0;
          code_value_next  = 12'd0;
          if (digit_count == 2'd0) begin
            // first byte not hex: passed through as is, quote or not
            job.res[n] = '{c, KIND_DATA}; n = n + 3'd1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < digit_count) begin
                job.res[n] = '{held_digits[i], KIND_DATA}; n = n + 3'd1;
              end
            end
            do_normal = 1'b1;
          end
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase

    if (do_normal) begin
      if (c == CH_NL) begin
        // raw newline dropped
      end else if (c == CH_BSLASH) begin
        mode_next = MODE_ESCAPE;
      end else if (c == quote) begin
        job.res[n] = '{8'h00, KIND_CLOSED}; n = n + 3'd1;
        closed           = 1'b1;
        mode_next        = MODE_NORMAL;
        digit_count_next = 2'd0;
        code_value_next  = 12'd0;
      end else begin
        job.res[n] = '{c, KIND_DATA}; n = n + 3'd1;
      end
    end

    if (in_data.last_byte && !closed) begin
      job.res[n] = '{8'h00, KIND_ERROR}; n = n + 3'd1;
      mode_next        = MODE_NORMAL;
      digit_count_next = 2'd0;
      code_value_next  = 12'd0;
    end

    job.count = n;
    job_push  = accept && (n != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      digit_count <= 2'd0;
      code_value  <= 12'd0;
    end else if (accept) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      code_value  <= code_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_wr) begin
      held_digits[digit_count] <= in_data.in_byte;
    end
  end

endmodule

// ----- rtl/jsu_job_fifo.sv -----
module jsu_job_fifo
  import jsu_pkg::*;
#(
  parameter int JobDepth = JOB_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output job_t rd_data,
  output logic not_empty
);

  localparam int PtrW = $clog2(JobDepth);
  localparam int CntW = $clog2(JobDepth + 1);

  job_t            slots [JobDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] cnt;

  assign full      = (cnt == CntW'(JobDepth));
  assign not_empty = (cnt != '0);
  assign rd_data   = slots[rd_ptr];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(JobDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) wr_ptr <= ptr_inc(wr_ptr);
      if (rd_en) rd_ptr <= ptr_inc(rd_ptr);
      if (wr_en && !rd_en) begin
        cnt <= cnt + CntW'(1);
      end else if (rd_en && !wr_en) begin
        cnt <= cnt - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

endmodule

// ----- rtl/jsu_back.sv -----
module jsu_back
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_avail,
  input  job_t      job,
  output logic      job_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic [2:0] idx;
  logic       out_valid;
  logic       load;
  logic       is_last;
  res_entry_t cur;

  assign cur     = job.res[idx];
  assign is_last = (idx == job.count - 3'd1);
  assign load    = job_avail && (!out_valid || pop);
  assign job_pop = load && is_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte    <= cur.out_byte;
      out_data.kind        <= cur.kind;
      out_data.last_of_run <= is_last;
    end
  end

endmodule

// ----- rtl/json_string_unescaper_unit.sv -----
// JSON string unescaper. Takes the body bytes of a quoted string one beat at a
// time and gives the unescaped bytes, a "closed" marker on the matching quote,
// or an "unterminated" error after a final byte that does not close the string.
// \uXXXX escapes become one to three UTF-8 bytes; malformed \u sequences are
// passed through literally. One input beat is taken every cycle while the job
// queue (JobDepth entries) has room, and one result beat leaves every cycle
// while pop is held and results wait. A byte causes zero to seven results, so
// the single-result output register sets the sustained rate once the queue is
// full. Results pass through the job queue and then the output register.
module json_string_unescaper_unit
  import jsu_pkg::*;
#(
  parameter int JobDepth = JOB_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_head;
  logic job_avail;
  logic job_pop;

  assign accept = push && !full;

  // front: decode state and per-beat result list
  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_data  (in_data),
    .job_push (job_push),
    .job      (job_in)
  );

  // jobs with no results never enter the queue
  jsu_job_fifo #(
    .JobDepth (JobDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (job_push),
    .wr_data   (job_in),
    .full      (full),
    .rd_en     (job_pop),
    .rd_data   (job_head),
    .not_empty (job_avail)
  );

  // back: one result beat per cycle into the output register while it is empty or popped
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (job_avail),
    .job       (job_head),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // closed and error markers always end their run
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.kind != KIND_DATA) |-> out_data.last_of_run)
    else $error("marker result not last of run");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_data.kind == KIND_DATA || out_data.kind == KIND_CLOSED ||
                out_data.kind == KIND_ERROR))
    else $error("bad result kind");

  a_job_nonzero: assert property (@(posedge clk) disable iff (rst)
    job_avail |-> (job_head.count != 3'd0 && job_head.count <= 3'(MAX_RESULTS)))
    else $error("queued job has bad count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not empty after reset");
`endif

endmodule

// ----- verif/json_string_unescaper_unit_tb.sv -----
module json_string_unescaper_unit_tb;
  import jsu_pkg::*;

  // Run limit in clock cycles.
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 410;
  localparam int IDLE_PCT    = 26;
  // Receiver hold-off: starts once this many results have left; HOLD_LEN sets its length.
  localparam int HOLD_AFTER  = 60;
  localparam int HOLD_LEN    = 300;
  // Cycles to linger once nothing is due.
  localparam int TAIL_CYCLES = 16;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_U   = 8'h75;
  // Escape letters that map to a single byte.
  localparam logic [63:0] ESC_SET = {"b", "n", "r", "t", "f", "\\", "/", "\""};

  // Decoder position within the string body.
  typedef enum logic [1:0] {
    SCAN_TEXT,
    SCAN_ESC,
    SCAN_HEX
  } scan_t;

  // One pending input beat; hush makes the sender wait until nothing is due.
  typedef struct packed {
    logic     hush;
    in_item_t beat;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_data;

  json_string_unescaper_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stim_t     byte_q[$];   // beats still to offer
  out_item_t due_q[$];    // decoded results not yet seen
  out_item_t burst_q[$];  // results of the beat being decoded

  int n_in = 0;
  int n_out = 0;
  int errors = 0;
  int cycles = 0;
  int n_closed = 0;
  int n_unterm = 0;
  int n_bad_u = 0;
  int n_cp[3] = '{0, 0, 0};

  // Decoder state mirrored on the testbench side.
  scan_t      scan = SCAN_TEXT;
  logic [1:0] ndig = 2'd0;
  logic [11:0] acc = 12'd0;
  logic [7:0] digits[3];

  // Both sides run flat out while this holds.
  logic calm;
  assign calm = (n_in >= 240) && (n_in < 320);

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Own hex check: '0'..'9' keep the low nibble, letters are low nibble + 9.
  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
    nib = 4'd0;
    if (c inside {["0":"9"]}) begin
      nib = c[3:0];
    end else if (c inside {["a":"f"], ["A":"F"]}) begin
      nib = c[3:0] + 4'd9;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void put(logic [7:0] b, kind_t k);
    out_item_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.last_of_run = 1'b0;
    burst_q.push_back(r);
  endfunction

  function automatic void restart();
    scan = SCAN_TEXT;
    ndig = 2'd0;
    acc  = 12'd0;
  endfunction

  // Plain-text handling; returns 1 when the byte closes the string.
  function automatic logic text_byte(logic [7:0] c, logic [7:0] closer);
    if (c == CH_NL) return 1'b0;            // raw newline vanishes
    if (c == CH_BSL) begin
      scan = SCAN_ESC;
      return 1'b0;
    end
    if (c == closer) begin
      put(8'h00, KIND_CLOSED);
      n_closed++;
      restart();
      return 1'b1;
    end
    put(c, KIND_DATA);
    return 1'b0;
  endfunction

  // Works out the results of one accepted beat and queues them as due.
  task automatic unescape_byte(in_item_t it);
    logic [7:0]  c;
    logic [7:0]  closer;
    logic [3:0]  nib;
    logic [15:0] cp;
    logic        closed;
    int          k;
    out_item_t   r;
    c      = it.in_byte;
    closer = it.quote_single ? CH_SQ : CH_DQ;
    closed = 1'b0;
    burst_q.delete();
    case (scan)
      SCAN_TEXT: begin
        closed = text_byte(c, closer);
      end
      SCAN_ESC: begin
        scan = SCAN_TEXT;
        case (c)
          "b":  put(8'h08, KIND_DATA);
          "n":  put(8'h0A, KIND_DATA);
          "r":  put(8'h0D, KIND_DATA);
          "t":  put(8'h09, KIND_DATA);
          "f":  put(8'h0C, KIND_DATA);
          "\\": put(CH_BSL, KIND_DATA);
          "/":  put("/", KIND_DATA);
          "\"": put(CH_DQ, KIND_DATA);
          "u": begin
            scan = SCAN_HEX;
            ndig = 2'd0;
            acc  = 12'd0;
          end
          default: begin
            // unknown escape comes out literally
            put(CH_BSL, KIND_DATA);
            put(c, KIND_DATA);
          end
        endcase
      end
      default: begin
        if (hex_nibble(c, nib)) begin
          if (ndig < 2'd3) begin
            digits[ndig] = c;
            acc  = {acc[7:0], nib};
            ndig = ndig + 2'd1;
          end else begin
            // fourth digit: emit the code point as UTF-8
            cp = {acc, nib};
            if (cp < 16'h0080) begin
              put({1'b0, cp[6:0]}, KIND_DATA);
              n_cp[0]++;
            end else if (cp < 16'h0800) begin
              put({2'b11, cp[11:6]}, KIND_DATA);
              put({2'b10, cp[5:0]}, KIND_DATA);
              n_cp[1]++;
            end else begin
              put({4'hE, cp[15:12]}, KIND_DATA);
              put({2'b10, cp[11:6]}, KIND_DATA);
              put({2'b10, cp[5:0]}, KIND_DATA);
              n_cp[2]++;
            end
            restart();
          end
        end else begin
          // broken \u: replay the prefix and whatever digits were held
          k = int'(ndig);
          n_bad_u++;
          put(CH_BSL, KIND_DATA);
          put(CH_U, KIND_DATA);
          restart();
          if (k == 0) begin
            put(c, KIND_DATA);              // taken as is, quote or not
          end else begin
            for (int i = 0; i < k; i++) put(digits[i], KIND_DATA);
            closed = text_byte(c, closer);
          end
        end
      end
    endcase
    if (it.last_byte && !closed) begin
      put(8'h00, KIND_ERROR);
      n_unterm++;
      restart();
    end
    if (burst_q.size() > 0) begin
      r = burst_q.pop_back();
      r.last_of_run = 1'b1;
      burst_q.push_back(r);
    end
    foreach (burst_q[i]) due_q.push_back(burst_q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add(logic [7:0] b, logic q, logic lst);
    stim_t s;
    s.hush              = 1'b0;
    s.beat.in_byte      = b;
    s.beat.quote_single = q;
    s.beat.last_byte    = lst;
    byte_q.push_back(s);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, logic up);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (up ? 8'h37 : 8'h57) + 8'(n);
  endfunction

  function automatic logic [7:0] pick_nonhex();
    logic [7:0] c;
    logic [3:0] nib;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c, nib));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers beats from byte_q, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    stim_t nxt;
    logic  offer;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        unescape_byte(in_data);
        n_in++;
      end
      // a stalled beat stays up unchanged; otherwise choose the next one
      if (!push || !full) begin
        offer = (byte_q.size() > 0) && (!byte_q[0].hush || due_q.size() == 0) &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT);
        if (offer) begin
          nxt = byte_q.pop_front();
          in_data <= nxt.beat;
        end
        push <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each popped beat against the oldest due result
  // ---------------------------------------------------------------------------
  int   hold_left = 0;
  logic held = 1'b0;

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_out++;
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing due: expected none, got %h", $time, out_data);
        end else begin
          want = due_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte,
                     out_data.out_byte);
          end
          if (out_data.kind !== want.kind) begin
            errors++;
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, out_data.kind);
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            errors++;
            $display("%0t: last_of_run expected %b, got %b", $time, want.last_of_run,
                     out_data.last_of_run);
          end
        end
      end
      // one long hold-off so the job queue fills and full rises
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!held && n_out >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results still due", $time, due_q.size());
      $display("json_string_unescaper_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic        q;
    logic [7:0]  closer;
    logic [7:0]  other;
    logic [15:0] cp;
    int          pick;
    int          k;
    int          pause_at[2];
    stim_t       tmp;

    // Directed: other quote kind passes, raw newline vanishes, extremes of the
    // byte, unterminated end, unknown escape, all three UTF-8 lengths, and a
    // broken \u both at the first digit and after one digit (that one closes).
    add(CH_SQ, 1'b0, 1'b0);
    add(CH_NL, 1'b0, 1'b0);
    add(8'h00, 1'b0, 1'b1);
    add(CH_BSL, 1'b0, 1'b0); add("q", 1'b0, 1'b0);
    add(CH_BSL, 1'b0, 1'b0); add(CH_U, 1'b0, 1'b0);
    add("0", 1'b0, 1'b0); add("0", 1'b0, 1'b0); add("4", 1'b0, 1'b0); add("1", 1'b0, 1'b0);
    add(CH_BSL, 1'b1, 1'b0); add(CH_U, 1'b1, 1'b0);
    add("0", 1'b1, 1'b0); add("7", 1'b1, 1'b0); add("e", 1'b1, 1'b0); add("9", 1'b1, 1'b0);
    add(CH_BSL, 1'b0, 1'b0); add(CH_U, 1'b0, 1'b0);
    add("F", 1'b0, 1'b0); add("f", 1'b0, 1'b0); add("f", 1'b0, 1'b0); add("F", 1'b0, 1'b0);
    add(CH_BSL, 1'b0, 1'b0); add(CH_U, 1'b0, 1'b0); add(8'hFF, 1'b0, 1'b0);
    add(CH_BSL, 1'b0, 1'b0); add(CH_U, 1'b0, 1'b0); add("7", 1'b0, 1'b0);
    add(CH_DQ, 1'b0, 1'b1);

    // Random: mostly well-formed string bodies with random content, a few
    // runs of raw noise, and some bodies that end without their quote.
    pause_at[0] = byte_q.size();
    while (byte_q.size() < ITEM_TARGET) begin
      q      = 1'($urandom_range(0, 1));
      closer = q ? CH_SQ : CH_DQ;
      other  = q ? CH_DQ : CH_SQ;
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 6))
          add(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              $urandom_range(0, 7) == 0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          pick = $urandom_range(0, 99);
          if (pick < 25) begin
            if ($urandom_range(0, 4) == 0) add(8'($urandom_range(0, 255)), q, 1'b0);
            else add(8'($urandom_range(8'h20, 8'h7E)), q, 1'b0);
          end else if (pick < 42) begin
            add(CH_BSL, q, 1'b0);
            add(ESC_SET[8 * $urandom_range(0, 7) +: 8], q, 1'b0);
          end else if (pick < 50) begin
            add(CH_BSL, q, 1'b0);
            add(8'($urandom_range(0, 255)), q, 1'b0);
          end else if (pick < 72) begin
            // full \u escape, spread over the three encoded lengths
            case ($urandom_range(0, 2))
              0:       cp = 16'($urandom_range(0, 16'h007F));
              1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
              default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            add(CH_BSL, q, 1'b0);
            add(CH_U, q, 1'b0);
            for (int i = 3; i >= 0; i--)
              add(hex_char(cp[4 * i +: 4], 1'($urandom_range(0, 1))), q, 1'b0);
          end else if (pick < 84) begin
            // broken \u: zero to three digits, then a byte that is not hex
            k = $urandom_range(0, 3);
            add(CH_BSL, q, 1'b0);
            add(CH_U, q, 1'b0);
            repeat (k) add(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                           q, 1'b0);
            pick = $urandom_range(0, 99);
            if (pick < 30) add(closer, q, 1'b0);
            else if (pick < 45) add(CH_BSL, q, 1'b0);
            else if (pick < 55) add(CH_NL, q, 1'b0);
            else add(pick_nonhex(), q, 1'b0);
          end else if (pick < 92) begin
            add(CH_NL, q, 1'b0);
          end else begin
            add(other, q, 1'b0);
          end
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          add(closer, q, $urandom_range(0, 3) == 0);
        end else if (pick < 95) begin
          // buffer ends inside the body
          tmp = byte_q.pop_back();
          tmp.beat.last_byte = 1'b1;
          byte_q.push_back(tmp);
        end
        // otherwise the body simply runs on into the next one
      end
    end

    // sender drains everything before the first random beat and mid-run
    pause_at[1] = 220;
    foreach (pause_at[j]) begin
      tmp = byte_q[pause_at[j]];
      tmp.hush = 1'b1;
      byte_q[pause_at[j]] = tmp;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || push || due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bytes in, %0d results out; %0d strings closed, %0d unterminated",
             n_in, n_out, n_closed, n_unterm);
    $display("\\u decoded to 1/2/3 bytes: %0d/%0d/%0d, malformed \\u: %0d",
             n_cp[0], n_cp[1], n_cp[2], n_bad_u);
    if (errors == 0 && due_q.size() == 0) begin
      $display("json_string_unescaper_unit: match");
    end else begin
      $display("json_string_unescaper_unit: mismatch");
    end
    $finish;
  end

endmodule
